FILE: hdl/periodic_timer_table_macros.svh
// Assertion macros shared by the periodic timer table RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef PERIODIC_TIMER_TABLE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PTT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("periodic_timer_table: check failed");

`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("periodic_timer_table: check failed");

`else

`define PTT_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`define PTT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/ptt_pkg.sv
// Package for the periodic timer table: codes, sizes and the cell control bundle.
// No dependencies.
package ptt_pkg;

	localparam int MAX_TIMERS_DEF = 8;
	localparam int MAX_RESULTS    = 8;
	localparam int CNT_W          = $clog2(MAX_RESULTS + 1);
	localparam logic [15:0] TICK_STEP_RST = 16'd1;

	typedef enum logic [1:0] {
		OP_REG  = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2,
		OP_NONE = 2'd3
	} ptt_op_t;

	typedef enum logic [1:0] {
		KIND_REG  = 2'd0,
		KIND_FULL = 2'd1,
		KIND_FIRE = 2'd2,
		KIND_READ = 2'd3
	} ptt_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EVAL,
		ST_SCAN
	} ptt_state_t;

	typedef struct packed {
		logic        eval;
		logic        advance;
		logic        wrap;
		logic [31:0] now;
		logic [31:0] wr_interval;
		logic [31:0] wr_expiry;
	} ptt_cell_ctl_t;

endpackage

FILE: hdl/ptt_req_if.sv
// Request channel of the periodic timer table: op and interval per beat.
// No dependencies.
interface ptt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [31:0] interval;

	modport source (output valid, output op, output interval, input ready);
	modport sink   (input valid, input op, input interval, output ready);
endinterface

FILE: hdl/ptt_rsp_if.sv
// Response channel of the periodic timer table: one event per beat.
// No dependencies.
interface ptt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [2:0]  timer_slot;
	logic [31:0] now_ticks;
	logic        last;

	modport source (output valid, output kind, output timer_slot, output now_ticks,
		output last, input ready);
	modport sink   (input valid, input kind, input timer_slot, input now_ticks,
		input last, output ready);
endinterface

FILE: hdl/ptt_cfg_if.sv
// Configuration write channel of the periodic timer table: tick step per beat.
// No dependencies.
interface ptt_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] tick_step;

	modport source (output valid, output tick_step, input ready);
	modport sink   (input valid, input tick_step, output ready);
endinterface

FILE: hdl/ptt_cell.sv
// One timer slot: interval, expiry, due flag and the scan token.
// Depends on ptt_pkg.
module ptt_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ptt_pkg::ptt_cell_ctl_t ctl,
	input  logic                  wr_en,
	input  logic                  active,
	input  logic                  tok_load,
	input  logic                  tok_in,
	input  logic                  below_in,
	output logic                  tok_q,
	output logic                  fire_q,
	output logic                  below_out
);

	logic [31:0] interval_q;
	logic [31:0] expiry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= 1'b0;
			fire_q <= 1'b0;
		end else begin
			if (ctl.eval) begin
				fire_q <= active & (ctl.wrap | (ctl.now >= expiry_q));
				tok_q  <= tok_load;
			end else if (ctl.advance) begin
				tok_q  <= tok_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			interval_q <= ctl.wr_interval;
			expiry_q   <= ctl.wr_expiry;
		end else if (ctl.advance && tok_q && fire_q) begin
			expiry_q   <= ctl.now + interval_q;
		end
	end

	// due anywhere at or below this slot
	assign below_out = below_in | fire_q;

endmodule

FILE: hdl/periodic_timer_table.sv
// Periodic timer table top level: sequencer, tick counter and the row of slot cells.
// Depends on ptt_pkg, the three channel interfaces, ptt_cell and the macro header.
//
// Usage:
//   req carries op (register, tick, read) and interval; rsp returns events with
//   kind, timer_slot, now_ticks and last; cfg writes the 16-bit tick step.
//   A request beat is taken whenever the block is idle, even if an earlier
//   event still waits in the response register.
//   Register and read: 1 beat out, loaded once the output register is free.
//   Tick: the counter is updated in EXEC and compared in EVAL, then the scan token
//   walks the row of cells from the newest slot down, one slot per cycle while no
//   due slot waits on a stalled response.
//   Events leave newest slot first; the final one has last set. A tick with
//   nothing due gives no beat. Only the first 8 due slots produce beats; all
//   due slots are rescheduled.
//   A stalled response holds the event in the output register; the walk waits
//   at a due slot until the register frees.
//   Reset clears the counter and the table and sets the tick step to 1.
`include "periodic_timer_table_macros.svh"

module periodic_timer_table #(
	parameter int MAX_TIMERS = ptt_pkg::MAX_TIMERS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ptt_req_if.sink   req,
	ptt_rsp_if.source rsp,
	ptt_cfg_if.sink   cfg
);

	localparam int UW = $clog2(MAX_TIMERS + 1);
	localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

	ptt_pkg::ptt_state_t state_q, state_d;

	logic [1:0]             op_s1;
	logic [31:0]            interval_s1;
	logic [31:0]            counter_q;
	logic                   wrap_q;
	logic [15:0]            step_q;
	logic [UW-1:0]          used_q;
	logic [IW-1:0]          idx_q;
	logic [ptt_pkg::CNT_W-1:0] emit_cnt_q;

	logic                   out_valid_q;
	logic [1:0]             out_kind_q;
	logic [2:0]             out_slot_q;
	logic [31:0]            out_now_q;
	logic                   out_last_q;

	logic                   out_free;
	logic                   full;
	logic                   emit;
	ptt_pkg::ptt_kind_t     emit_kind;
	logic [2:0]             emit_slot;
	logic                   emit_last;
	logic                   wr_req;
	logic                   cnt_upd;
	logic                   eval;
	logic                   advance;
	logic                   cur_fire;
	logic                   cur_below;
	logic                   can_emit;

	ptt_pkg::ptt_cell_ctl_t cell_ctl;
	logic [MAX_TIMERS-1:0]  tok_vec;
	logic [MAX_TIMERS-1:0]  fire_vec;
	logic [MAX_TIMERS-1:0]  below_in_vec;
	logic [MAX_TIMERS-1:0]  below_out_vec;

	assign out_free = !out_valid_q || rsp.ready;
	assign full     = (used_q == UW'(MAX_TIMERS));
	assign cur_fire  = |(tok_vec & fire_vec);
	assign cur_below = |(tok_vec & below_in_vec);
	assign can_emit  = (emit_cnt_q < ptt_pkg::CNT_W'(ptt_pkg::MAX_RESULTS));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ptt_pkg::ST_IDLE: begin
				if (req.valid) state_d = ptt_pkg::ST_EXEC;
			end
			ptt_pkg::ST_EXEC: begin
				case (op_s1)
					ptt_pkg::OP_REG, ptt_pkg::OP_READ: begin
						if (out_free) state_d = ptt_pkg::ST_IDLE;
					end
					ptt_pkg::OP_TICK: state_d = ptt_pkg::ST_EVAL;
					default: state_d = ptt_pkg::ST_IDLE;
				endcase
			end
			ptt_pkg::ST_EVAL: begin
				state_d = (used_q == '0) ? ptt_pkg::ST_IDLE : ptt_pkg::ST_SCAN;
			end
			ptt_pkg::ST_SCAN: begin
				if (advance && idx_q == '0) state_d = ptt_pkg::ST_IDLE;
			end
			default: state_d = ptt_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req.ready = 1'b0;
		emit      = 1'b0;
		emit_kind = ptt_pkg::KIND_READ;
		emit_slot = 3'd0;
		emit_last = 1'b1;
		wr_req    = 1'b0;
		cnt_upd   = 1'b0;
		eval      = 1'b0;
		advance   = 1'b0;
		case (state_q)
			ptt_pkg::ST_IDLE: req.ready = 1'b1;
			ptt_pkg::ST_EXEC: begin
				case (op_s1)
					ptt_pkg::OP_REG: begin
						emit = out_free;
						if (full) begin
							emit_kind = ptt_pkg::KIND_FULL;
						end else begin
							emit_kind = ptt_pkg::KIND_REG;
							emit_slot = 3'(used_q);
							wr_req    = out_free;
						end
					end
					ptt_pkg::OP_READ: begin
						emit      = out_free;
						emit_kind = ptt_pkg::KIND_READ;
					end
					ptt_pkg::OP_TICK: cnt_upd = 1'b1;
					default: ;
				endcase
			end
			ptt_pkg::ST_EVAL: eval = 1'b1;
			ptt_pkg::ST_SCAN: begin
				advance   = !cur_fire || !can_emit || out_free;
				emit      = cur_fire && can_emit && out_free;
				emit_kind = ptt_pkg::KIND_FIRE;
				emit_slot = 3'(idx_q);
				emit_last = !cur_below ||
					(emit_cnt_q == ptt_pkg::CNT_W'(ptt_pkg::MAX_RESULTS - 1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptt_pkg::ST_IDLE;
			counter_q   <= '0;
			wrap_q      <= 1'b0;
			step_q      <= ptt_pkg::TICK_STEP_RST;
			used_q      <= '0;
			idx_q       <= '0;
			emit_cnt_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) step_q <= cfg.tick_step;
			if (cnt_upd) {wrap_q, counter_q} <= {1'b0, counter_q} + 33'(step_q);
			if (wr_req) used_q <= used_q + UW'(1);
			if (eval) begin
				idx_q      <= IW'(used_q - UW'(1));
				emit_cnt_q <= '0;
			end else if (advance) begin
				idx_q <= idx_q - IW'(1);
			end
			if (emit && state_q == ptt_pkg::ST_SCAN)
				emit_cnt_q <= emit_cnt_q + ptt_pkg::CNT_W'(1);
			if (emit) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1       <= req.op;
			interval_s1 <= req.interval;
		end
		if (emit) begin
			out_kind_q <= emit_kind;
			out_slot_q <= emit_slot;
			out_now_q  <= counter_q;
			out_last_q <= emit_last;
		end
	end

	assign cfg.ready      = 1'b1;
	assign rsp.valid      = out_valid_q;
	assign rsp.kind       = out_kind_q;
	assign rsp.timer_slot = out_slot_q;
	assign rsp.now_ticks  = out_now_q;
	assign rsp.last       = out_last_q;

	assign cell_ctl.eval        = eval;
	assign cell_ctl.advance     = advance;
	assign cell_ctl.wrap        = wrap_q;
	assign cell_ctl.now         = counter_q;
	assign cell_ctl.wr_interval = interval_s1;
	assign cell_ctl.wr_expiry   = counter_q + interval_s1;

	for (genvar i = 0; i < MAX_TIMERS; i++) begin : g_cell
		logic tok_in;
		if (i == MAX_TIMERS - 1) begin : g_top
			assign tok_in = 1'b0;
		end else begin : g_mid
			assign tok_in = tok_vec[i+1];
		end
		if (i == 0) begin : g_bot
			assign below_in_vec[i] = 1'b0;
		end else begin : g_up
			assign below_in_vec[i] = below_out_vec[i-1];
		end

		ptt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.wr_en     (wr_req && used_q == UW'(i)),
			.active    (UW'(i) < used_q),
			.tok_load  (UW'(i + 1) == used_q),
			.tok_in    (tok_in),
			.below_in  (below_in_vec[i]),
			.tok_q     (tok_vec[i]),
			.fire_q    (fire_vec[i]),
			.below_out (below_out_vec[i])
		);
	end

	`PTT_ASSERT_IMPLY(a_tok_onehot, clk, arst_n, 1'b1, $onehot0(tok_vec))
	`PTT_ASSERT_IMPLY(a_used_range, clk, arst_n, 1'b1, used_q <= UW'(MAX_TIMERS))
	`PTT_ASSERT_IMPLY(a_emit_cap, clk, arst_n, 1'b1,
		emit_cnt_q <= ptt_pkg::CNT_W'(ptt_pkg::MAX_RESULTS))
	`PTT_ASSERT_NEXT(a_tick_add, clk, arst_n, cnt_upd,
		counter_q == $past(counter_q + 32'(step_q)))
	`PTT_ASSERT_IMPLY(a_scan_token, clk, arst_n, state_q == ptt_pkg::ST_SCAN,
		tok_vec[idx_q] == 1'b1)

endmodule
